FILE: rtl/mtf_pkg.sv
// ============================================================================
// mtf_pkg
// Shared types and constants for the movetext token filter.
// ============================================================================
package mtf_pkg;

    localparam int TOKEN_CAPACITY = 16;
    localparam int ADDR_W         = $clog2(TOKEN_CAPACITY);
    localparam int LEN_W          = $clog2(TOKEN_CAPACITY + 1);

    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LOW_MAX  = 8'd31;
    localparam logic [7:0] CH_HIGH_MIN = 8'd126;

    typedef enum logic [1:0] {
        SKIP_NONE    = 2'd0,
        SKIP_BRACE   = 2'd1,
        SKIP_BRACKET = 2'd2,
        SKIP_LINE    = 2'd3
    } skip_mode_t;

    // Decoded meaning of one byte in the current skip context
    typedef struct packed {
        skip_mode_t skip_next;
        logic       is_store;
        logic       is_dot;
        logic       is_space;
    } byte_class_t;

endpackage

FILE: rtl/mtf_token_ram.sv
// ============================================================================
// mtf_token_ram
// Simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module mtf_token_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/mtf_byte_class.sv
// ============================================================================
// mtf_byte_class
// Decodes one raw byte against the current skip mode.
// ============================================================================
module mtf_byte_class
    import mtf_pkg::*;
(
    input  logic [7:0]  ch,
    input  skip_mode_t  skip_mode,
    output byte_class_t cls
);

    logic [7:0] c_norm;
    logic       printable;

    assign c_norm    = (ch == CH_NEWLINE) ? CH_SPACE : ch;
    assign printable = (c_norm > CH_LOW_MAX) && (c_norm < CH_HIGH_MIN);

    always_comb begin
        cls           = '0;
        cls.skip_next = skip_mode;
        unique case (skip_mode)
            SKIP_BRACE: begin
                if (ch == CH_RBRACE) cls.skip_next = SKIP_NONE;
            end
            SKIP_BRACKET: begin
                if (ch == CH_RBRACKET) cls.skip_next = SKIP_NONE;
            end
            SKIP_LINE: begin
                if (ch == CH_NEWLINE) cls.skip_next = SKIP_NONE;
            end
            SKIP_NONE: begin
                if (printable) begin
                    priority case (c_norm)
                        CH_LBRACE:   cls.skip_next = SKIP_BRACE;
                        CH_LBRACKET: cls.skip_next = SKIP_BRACKET;
                        CH_SEMI:     cls.skip_next = SKIP_LINE;
                        CH_DOT:      cls.is_dot    = 1'b1;
                        CH_SPACE:    cls.is_space  = 1'b1;
                        default:     cls.is_store  = 1'b1;
                    endcase
                end
            end
            default: cls.skip_next = SKIP_NONE;
        endcase
    end

endmodule

FILE: rtl/movetext_token_filter.sv
// ============================================================================
// movetext_token_filter
// Chess movetext tokenizer: filters bytes, drops comments and move numbers,
// and emits space-separated tokens one character per output request.
// ============================================================================
//
//  channel | dir | tdata        | tlast        | tuser
//  --------+-----+--------------+--------------+------------------
//  s_      | in  | [7:0] ch     | end_of_text  | -
//  m_      | out | [7:0] out_char | last_in_run | [0] token_overflowed
//
//  A byte that emits nothing leaves the sequencer idle. A byte that finishes
//  a token moves it through ST_PRIME, ST_EMIT for each of its N characters and
//  ST_SPACE if a space ended the token; the token RAM's single read port,
//  primed in ST_PRIME, gives one character per cycle unless the output stalls.
//  Reset clears the skip mode, token length, overflow flag, sequencer and
//  output valid; the token RAM is not cleared, since only written entries
//  are ever read. A stalled output holds the sequencer on its character;
//  the input is taken only while no token is being emitted.
//
module movetext_token_filter
    import mtf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // end_of_text

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // last_in_run
    output logic       m_tuser    // [0] token_overflowed
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_SPACE = 4'b1000
    } state_t;

    // Sequencer and token state
    state_t            state_reg, state_next;
    skip_mode_t        skip_reg, skip_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;

    // Emission context, captured when a token is handed to the sequencer
    logic [LEN_W-1:0]  emit_len_reg, emit_len_next;
    logic              emit_ovf_reg, emit_ovf_next;
    logic              emit_space_reg, emit_space_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    // Output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    byte_class_t       cls;
    logic              s_accept;
    logic              out_free;
    logic              out_load;
    logic              room;
    logic [LEN_W-1:0]  len_after;
    logic              ovf_after;
    logic              ram_wr_en;
    logic [7:0]        ram_rd_data;
    logic [LEN_W-1:0]  emit_len_m1;
    logic              at_last_char;

    mtf_byte_class u_class (
        .ch        (s_tdata),
        .skip_mode (skip_reg),
        .cls       (cls)
    );

    // Read address is the next index, so read data always matches idx_reg
    mtf_token_ram #(
        .DATA_W (8),
        .DEPTH  (TOKEN_CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (idx_next),
        .rd_data (ram_rd_data)
    );

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign room         = (len_reg < LEN_W'(TOKEN_CAPACITY));
    assign ram_wr_en    = s_accept && cls.is_store && room;
    assign emit_len_m1  = emit_len_reg - LEN_W'(1);
    assign at_last_char = (idx_reg == emit_len_m1[ADDR_W-1:0]);

    // Token length and overflow after folding in the accepted byte
    always_comb begin
        len_after = len_reg;
        ovf_after = ovf_reg;
        if (cls.is_dot) begin
            len_after = '0;
            ovf_after = 1'b0;
        end else if (cls.is_store) begin
            if (room) len_after = len_reg + LEN_W'(1);
            else      ovf_after = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        skip_next       = skip_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        emit_len_next   = emit_len_reg;
        emit_ovf_next   = emit_ovf_reg;
        emit_space_next = emit_space_reg;
        idx_next        = idx_reg;
        out_load        = 1'b0;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // End of text abandons any skip in progress
                    skip_next = s_tlast ? SKIP_NONE : cls.skip_next;
                    idx_next  = '0;
                    priority if (cls.is_space && (len_reg != '0)) begin
                        emit_len_next   = len_reg;
                        emit_ovf_next   = ovf_reg;
                        emit_space_next = 1'b1;
                        len_next        = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_PRIME;
                    end else if (s_tlast && (len_after != '0)) begin
                        emit_len_next   = len_after;
                        emit_ovf_next   = ovf_after;
                        emit_space_next = 1'b0;
                        len_next        = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_PRIME;
                    end else begin
                        len_next = len_after;
                        ovf_next = ovf_after;
                    end
                end
            end
            ST_PRIME: begin
                // First character read is in flight
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_tdata_next = ram_rd_data;
                    m_tlast_next = at_last_char && !emit_space_reg;
                    m_tuser_next = emit_ovf_reg;
                    if (at_last_char) begin
                        state_next = emit_space_reg ? ST_SPACE : ST_IDLE;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_SPACE: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_tdata_next = CH_SPACE;
                    m_tlast_next = 1'b1;
                    m_tuser_next = emit_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            skip_reg     <= SKIP_NONE;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            skip_reg     <= skip_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        emit_len_reg   <= emit_len_next;
        emit_ovf_reg   <= emit_ovf_next;
        emit_space_reg <= emit_space_next;
        idx_reg        <= idx_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Held token never exceeds capacity
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(TOKEN_CAPACITY))
        else $error("token length past capacity");

    // Emission index stays inside the captured token
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ({1'b0, idx_reg} < {1'b0, emit_len_reg}))
        else $error("emit index past token end");

    // End of text always returns the skip mode to normal
    a_eot_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (skip_reg == SKIP_NONE))
        else $error("skip mode survived end of text");

    // Loading the final result of a run returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_tlast_next) |=> (state_reg == ST_IDLE) && m_tvalid_reg)
        else $error("run ended without returning to idle");

endmodule
